// ===== hw/rtl/equal_count_grey_quantizer_core_assert.svh =====
// Assertion macros used by the checker file of the grey quantizer.
`ifndef EQUAL_COUNT_GREY_QUANTIZER_CORE_ASSERT_SVH
`define EQUAL_COUNT_GREY_QUANTIZER_CORE_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define ECGQ_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ECGQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ecgq_pkg.sv =====
// Shared types and constants of the equal-count grey quantizer.
package ecgq_pkg;

	localparam int ADDR_BITS   = 24;
	localparam int GREY_BITS   = 16;
	localparam int LEVEL_BITS  = 8;
	localparam int CNT_BITS    = 25;
	localparam int NL_BITS     = 9;
	localparam int MAX_LEVELS  = 256;

	localparam int DIV_STEPS    = CNT_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	localparam int IN_TDATA_BITS   = 40;
	localparam int OUT_TDATA_BITS  = 48;
	localparam int OUT_TUSER_BITS  = 2;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 25;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_PIXELS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_LEVELS   = 2'd1;

	typedef logic [CNT_BITS-1:0] cnt_t;
	typedef logic [NL_BITS-1:0]  nl_t;

	typedef struct packed {
		logic start;
		cnt_t dividend;
		nl_t  divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		cnt_t quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/ecgq_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the level quotas.
module ecgq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ecgq_pkg::div_req_t req,
	output ecgq_pkg::div_rsp_t rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [ecgq_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [ecgq_pkg::NL_BITS-1:0]      part_q;
	ecgq_pkg::cnt_t                    quo_q;
	ecgq_pkg::nl_t                     dsr_q;

	logic [ecgq_pkg::NL_BITS:0] trial;
	logic [ecgq_pkg::NL_BITS:0] diff;
	logic                       ge;

	assign trial = {part_q, quo_q[ecgq_pkg::CNT_BITS-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ecgq_pkg::DIV_CNT_BITS'(ecgq_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top of quo_q while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			part_q <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			part_q <= ge ? diff[ecgq_pkg::NL_BITS-1:0] : trial[ecgq_pkg::NL_BITS-1:0];
			quo_q  <= {quo_q[ecgq_pkg::CNT_BITS-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hw/rtl/equal_count_grey_quantizer_core.sv =====
// Equal-count grey quantizer: assigns each sorted pixel a level of about equal population.
//
// Input stream (s_*): one pixel per transfer, tdata = pixel_index, grey_value, in
// ascending grey order. Output stream (m_*): one result per pixel, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 total_pixels,
// 1 num_levels); write only while no pixel is in flight.
// Flow: an ordinary pixel goes from its transfer through the evaluate and emit
// states to its result being loaded, and the next pixel can be taken on the
// following cycle. The first pixel of a pass and every level that closes cost
// one quota division in the shared bit-serial divider, a 25-bit quotient plus
// the start and done hand-off; a pixel skipping several empty levels pays that
// once per level. A pixel beyond total_pixels skips to emit and only reports overrun.
// One pixel is worked on at a time; s_tready is high only while the sequencer
// waits for input. The result sits in an output register, so a new pixel is
// taken while it waits; if the receiver holds m_tready low the next result
// waits in the sequencer until the register drains.
// Reset clears the pass state and sets both registers to 1.
module equal_count_grey_quantizer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ecgq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [ecgq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// pixel_index [23:0], grey_value [39:24]
	input  logic [ecgq_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// out_index [23:0], level [31:24], levels_used [40:32], zero fill [47:41]
	output logic [ecgq_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
	// starts_level [0], overrun [1]
	output logic [ecgq_pkg::OUT_TUSER_BITS-1:0]   m_tuser,
	output logic                                  m_tlast
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EVAL, ST_EMIT} state_t;

	state_t                                 state_q;
	ecgq_pkg::cnt_t                         total_q;
	ecgq_pkg::nl_t                          nlev_q;
	logic [ecgq_pkg::LEVEL_BITS-1:0]        cl_q;
	ecgq_pkg::cnt_t                         lc_q;
	ecgq_pkg::cnt_t                         rem_q;
	ecgq_pkg::cnt_t                         quota_q;
	logic [ecgq_pkg::GREY_BITS-1:0]         bgrey_q;
	logic                                   ext_q;
	ecgq_pkg::cnt_t                         pos_q;
	logic                                   ovr_q;
	ecgq_pkg::div_req_t                     div_req_q;
	logic                                   m_tvalid_q;

	logic [ecgq_pkg::ADDR_BITS-1:0]         idx_q;
	logic [ecgq_pkg::GREY_BITS-1:0]         grey_q;
	logic [ecgq_pkg::OUT_TDATA_BITS-1:0]    m_tdata_q;
	logic [ecgq_pkg::OUT_TUSER_BITS-1:0]    m_tuser_q;
	logic                                   m_tlast_q;

	ecgq_pkg::div_rsp_t                     div_rsp;

	ecgq_pkg::cnt_t                         total_eff;
	ecgq_pkg::nl_t                          nl_eff;
	ecgq_pkg::nl_t                          cl_inc;
	logic                                   last_lvl;
	logic                                   stop_take;
	logic                                   stop_ext;
	ecgq_pkg::cnt_t                         rem_next;
	ecgq_pkg::cnt_t                         pos_inc;
	logic                                   end_pass;
	logic                                   in_xfer;
	logic                                   load_out;

	always_comb begin
		total_eff = (total_q == '0) ? ecgq_pkg::CNT_BITS'(1) : total_q;
		if (nlev_q == '0) begin
			nl_eff = ecgq_pkg::NL_BITS'(1);
		end else if (nlev_q > ecgq_pkg::NL_BITS'(ecgq_pkg::MAX_LEVELS)) begin
			nl_eff = ecgq_pkg::NL_BITS'(ecgq_pkg::MAX_LEVELS);
		end else begin
			nl_eff = nlev_q;
		end
	end

	assign cl_inc    = {1'b0, cl_q} + 1'b1;
	assign last_lvl  = cl_inc >= nl_eff;
	// Unless a level is extending, it takes the pixel outright while short of its quota or when it is the last level.
	assign stop_take = !ext_q && ((lc_q < quota_q) || last_lvl);
	assign stop_ext  = (grey_q == bgrey_q) || last_lvl;
	assign rem_next  = rem_q - lc_q;
	assign pos_inc   = pos_q + 1'b1;
	assign end_pass  = pos_inc >= total_eff;
	assign in_xfer   = s_tvalid && s_tready;
	assign load_out  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	ecgq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= ecgq_pkg::CNT_BITS'(1);
			nlev_q     <= ecgq_pkg::NL_BITS'(1);
			cl_q       <= '0;
			lc_q       <= '0;
			rem_q      <= '0;
			quota_q    <= '0;
			bgrey_q    <= '0;
			ext_q      <= 1'b0;
			pos_q      <= '0;
			ovr_q      <= 1'b0;
			div_req_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					ecgq_pkg::CFG_TOTAL_PIXELS: total_q <= cfg_data;
					ecgq_pkg::CFG_NUM_LEVELS:   nlev_q  <= cfg_data[ecgq_pkg::NL_BITS-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (pos_q >= total_eff) begin
							ovr_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else if (pos_q == '0) begin
							ovr_q              <= 1'b0;
							cl_q               <= '0;
							lc_q               <= '0;
							rem_q              <= total_eff;
							bgrey_q            <= '0;
							ext_q              <= 1'b0;
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= total_eff;
							div_req_q.divisor  <= nl_eff;
							state_q            <= ST_DIV;
						end else begin
							ovr_q   <= 1'b0;
							state_q <= ST_EVAL;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						quota_q <= div_rsp.quotient;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (stop_take) begin
						bgrey_q <= grey_q;
						state_q <= ST_EMIT;
					end else if (stop_ext) begin
						ext_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						// Close the level and work out the quota of the next one.
						rem_q              <= rem_next;
						cl_q               <= cl_q + 1'b1;
						lc_q               <= '0;
						ext_q              <= 1'b0;
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= rem_next;
						div_req_q.divisor  <= nl_eff - cl_inc;
						state_q            <= ST_DIV;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
						if (!ovr_q) begin
							if (end_pass) begin
								cl_q    <= '0;
								lc_q    <= '0;
								rem_q   <= '0;
								quota_q <= '0;
								bgrey_q <= '0;
								ext_q   <= 1'b0;
								pos_q   <= '0;
							end else begin
								lc_q  <= lc_q + 1'b1;
								pos_q <= pos_inc;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			idx_q  <= s_tdata[ecgq_pkg::ADDR_BITS-1:0];
			grey_q <= s_tdata[ecgq_pkg::ADDR_BITS +: ecgq_pkg::GREY_BITS];
		end
		if (load_out) begin
			if (ovr_q) begin
				m_tdata_q <= {{(ecgq_pkg::OUT_TDATA_BITS - ecgq_pkg::ADDR_BITS){1'b0}}, idx_q};
				m_tuser_q <= 2'b10;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= {7'd0, (end_pass ? cl_inc : ecgq_pkg::NL_BITS'(0)), cl_q, idx_q};
				m_tuser_q <= {1'b0, lc_q == '0};
				m_tlast_q <= end_pass;
			end
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== hw/rtl/ecgq_checker.sv =====
// Port-level checks of the grey quantizer, bound to its top level.
`include "equal_count_grey_quantizer_core_assert.svh"

module ecgq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [ecgq_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	input logic [ecgq_pkg::OUT_TUSER_BITS-1:0] m_tuser,
	input logic                                m_tlast
);

	`ECGQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

	`ECGQ_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready, "pixel taken while the previous one is still in work")

	`ECGQ_ASSERT_SAME(a_overrun_clean, clk, arst_n, m_tvalid && m_tuser[1], m_tdata[47:24] == 24'd0 && !m_tuser[0] && !m_tlast, "overrun result carries level data")

	`ECGQ_ASSERT_SAME(a_used_only_last, clk, arst_n, m_tvalid && !m_tlast, m_tdata[40:32] == 9'd0, "levels_used set on a pixel that does not end the pass")

	`ECGQ_ASSERT_SAME(a_last_counts, clk, arst_n, m_tvalid && m_tlast, m_tdata[40:32] != 9'd0 && !m_tuser[1], "pass end without a level count")

endmodule

bind equal_count_grey_quantizer_core ecgq_checker u_ecgq_checker (.*);

// ===== test/equal_count_grey_quantizer_core_test.sv =====
// Self-checking testbench for the equal-count grey quantizer core.
`timescale 1ns / 100ps

module equal_count_grey_quantizer_core_test;
	import ecgq_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 2000000;
	localparam int unsigned RANDOM_PIXELS = 1500;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam longint unsigned CNT_MASK  = (64'd1 << CNT_BITS) - 1;
	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd2;

	// Fields in declaration order, so a typed concatenation matches the struct.
	typedef struct packed {
		logic [ADDR_BITS-1:0]  out_index;
		logic [LEVEL_BITS-1:0] level;
		logic                  starts_level;
		logic                  last_pixel;
		logic [NL_BITS-1:0]    levels_used;
		logic                  overrun;
	} grade_t;

	typedef enum {ROW_PIXEL, ROW_WRITE} row_kind_e;
	typedef enum {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_e;

	typedef struct {
		row_kind_e                 kind;
		logic [CFG_INDEX_BITS-1:0] reg_index;
		logic [CFG_DATA_BITS-1:0]  reg_value;
		logic [ADDR_BITS-1:0]      pixel_index;
		logic [GREY_BITS-1:0]      grey;
		bit                        typed;
		grade_t                    want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic [OUT_TUSER_BITS-1:0] m_tuser;
	logic                      m_tlast;

	// Register copies and pass state of the prediction.
	logic [CNT_BITS-1:0]  total_reg;
	logic [NL_BITS-1:0]   levels_reg;
	longint unsigned      lvl_now;
	longint unsigned      lvl_fill;
	longint unsigned      pixels_left;
	longint unsigned      lvl_quota;
	longint unsigned      pass_pos;
	logic [GREY_BITS-1:0] boundary_grey;
	bit                   past_quota;

	grade_t      pending_grades[$];
	stim_row_t   directed_rows[$];
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned graded_pixels;
	int unsigned cycles_run;
	int unsigned hold_left;
	pace_e       tx_pace;
	pace_e       rx_pace;

	equal_count_grey_quantizer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_pass_state();
		lvl_now = 0;
		lvl_fill = 0;
		pixels_left = 0;
		lvl_quota = 0;
		pass_pos = 0;
		boundary_grey = '0;
		past_quota = 1'b0;
	endfunction

	// Levels a pixel and advances the pass state; one call per accepted pixel.
	function automatic grade_t grade_pixel(input logic [ADDR_BITS-1:0] idx,
			input logic [GREY_BITS-1:0] g);
		grade_t          r;
		longint unsigned total;
		longint unsigned nl;
		longint unsigned next_lvl;
		bit              top;
		bit              settled;
		int              n;
		r = '0;
		r.out_index = idx;
		total = (total_reg == 0) ? 1 : total_reg;
		nl = (levels_reg == 0) ? 1 : levels_reg;
		if (nl > MAX_LEVELS)
			nl = MAX_LEVELS;
		if (pass_pos >= total) begin
			r.overrun = 1'b1;
			return r;
		end
		if (pass_pos == 0) begin
			lvl_now = 0;
			lvl_fill = 0;
			pixels_left = total;
			lvl_quota = total / nl;
			boundary_grey = '0;
			past_quota = 1'b0;
		end
		// A pixel may close several levels in a row when their quotas are zero.
		settled = 1'b0;
		n = 0;
		while (!settled && n <= MAX_LEVELS) begin
			top = (lvl_now + 1 >= nl);
			if (!past_quota) begin
				if (lvl_fill < lvl_quota || top) begin
					boundary_grey = g;
					settled = 1'b1;
				end else
					past_quota = 1'b1;
			end
			if (!settled) begin
				if (g == boundary_grey || top)
					settled = 1'b1;
				else begin
					pixels_left = (pixels_left - lvl_fill) & CNT_MASK;
					lvl_now++;
					lvl_quota = pixels_left / (nl - lvl_now);
					lvl_fill = 0;
					past_quota = 1'b0;
				end
			end
			n++;
		end
		r.level = lvl_now[LEVEL_BITS-1:0];
		r.starts_level = (lvl_fill == 0);
		lvl_fill = (lvl_fill + 1) & CNT_MASK;
		pass_pos++;
		if (pass_pos >= total) begin
			next_lvl = lvl_now + 1;
			r.last_pixel = 1'b1;
			r.levels_used = next_lvl[NL_BITS-1:0];
			clear_pass_state();
		end
		return r;
	endfunction

	function automatic stim_row_t pixel_row(input logic [ADDR_BITS-1:0] idx,
			input logic [GREY_BITS-1:0] g);
		stim_row_t row;
		row.kind = ROW_PIXEL;
		row.reg_index = '0;
		row.reg_value = '0;
		row.pixel_index = idx;
		row.grey = g;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t checked_row(input logic [ADDR_BITS-1:0] idx,
			input logic [GREY_BITS-1:0] g, input grade_t want);
		stim_row_t row;
		row = pixel_row(idx, g);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic stim_row_t write_row(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] value);
		stim_row_t row;
		row = pixel_row('0, '0);
		row.kind = ROW_WRITE;
		row.reg_index = index;
		row.reg_value = value;
		return row;
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] draw_level_count();
		int unsigned pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return 0;
		else if (pick == 1)
			return 1;
		else if (pick <= 9)
			return $urandom_range(8, 2);
		else if (pick <= 14)
			return $urandom_range(40, 9);
		else if (pick <= 17)
			return $urandom_range(255, 41);
		else if (pick == 18)
			return MAX_LEVELS;
		else
			return $urandom_range(511, 257);
	endfunction

	// Lets the block run dry: every predicted result has left the output.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_grades.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (index)
			CFG_TOTAL_PIXELS: total_reg = value;
			CFG_NUM_LEVELS:   levels_reg = value[NL_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic pause_sender();
		int unsigned gap;
		gap = 0;
		case (tx_pace)
			PACE_FULL: gap = 0;
			PACE_LIGHT: gap = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
			default: begin
				if ($urandom_range(24) == 0)
					gap = $urandom_range(60, 20);
				else if ($urandom_range(1) == 0)
					gap = $urandom_range(3, 1);
			end
		endcase
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Entered at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pixel(input logic [ADDR_BITS-1:0] idx, input logic [GREY_BITS-1:0] g,
			input bit typed, input grade_t want);
		grade_t outcome;
		s_tvalid <= 1'b1;
		s_tdata <= {g, idx};
		do @(posedge clk); while (!s_tready);
		outcome = grade_pixel(idx, g);
		if (!outcome.overrun)
			graded_pixels++;
		pending_grades.push_back(typed ? want : outcome);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles_run,
				pending_grades.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver side: stalls of random length, none at full pace, sparse or dense otherwise.
	always @(negedge clk) begin
		if (hold_left == 0) begin
			if (rx_pace == PACE_LIGHT && $urandom_range(3) == 0)
				hold_left = $urandom_range(3, 1);
			else if (rx_pace == PACE_HEAVY) begin
				if ($urandom_range(29) == 0)
					hold_left = $urandom_range(80, 20);
				else if ($urandom_range(5) == 0)
					hold_left = $urandom_range(3, 1);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin : check_results
		grade_t want;
		grade_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			seen.out_index = m_tdata[23:0];
			seen.level = m_tdata[31:24];
			seen.levels_used = m_tdata[40:32];
			seen.starts_level = m_tuser[0];
			seen.overrun = m_tuser[1];
			seen.last_pixel = m_tlast;
			if (pending_grades.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing expected: index %h level %0d",
						results_seen, seen.out_index, seen.level);
			end else begin
				want = pending_grades.pop_front();
				if (seen.out_index !== want.out_index || seen.level !== want.level
						|| seen.starts_level !== want.starts_level
						|| seen.last_pixel !== want.last_pixel
						|| seen.levels_used !== want.levels_used
						|| seen.overrun !== want.overrun) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d mismatch (index level start last used overrun)",
							results_seen);
						$display("  expected %h %0d %b %b %0d %b", want.out_index, want.level,
							want.starts_level, want.last_pixel, want.levels_used, want.overrun);
						$display("  actual   %h %0d %b %b %0d %b", seen.out_index, seen.level,
							seen.starts_level, seen.last_pixel, seen.levels_used, seen.overrun);
					end
				end
			end
		end
	end

	initial begin
		int unsigned     pick;
		int unsigned     burst;
		int unsigned     stride;
		int unsigned     step_grey;
		int unsigned     random_goal;
		longint unsigned eff_total;
		logic [GREY_BITS-1:0] shade;
		logic [GREY_BITS-1:0] g;
		bit              jumble;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_left = 0;
		mismatches = 0;
		results_seen = 0;
		graded_pixels = 0;
		cycles_run = 0;
		tx_pace = PACE_LIGHT;
		rx_pace = PACE_LIGHT;
		total_reg = 1;
		levels_reg = 1;
		clear_pass_state();
		shade = '0;
		stride = 1;

		// Expected words: {index, level, starts, last, used, overrun}.
		// Reset values: every pixel is a one-pixel pass on one level.
		directed_rows.push_back(checked_row(24'h000000, 16'h0000,
			{24'h000000, 8'd0, 1'b1, 1'b1, 9'd1, 1'b0}));
		directed_rows.push_back(checked_row(24'hFFFFFF, 16'hFFFF,
			{24'hFFFFFF, 8'd0, 1'b1, 1'b1, 9'd1, 1'b0}));
		// Zero in either register behaves as one.
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'd0));
		directed_rows.push_back(checked_row(24'h5A5A5A, 16'h00FF,
			{24'h5A5A5A, 8'd0, 1'b1, 1'b1, 9'd1, 1'b0}));
		directed_rows.push_back(write_row(CFG_NUM_LEVELS, 25'd0));
		directed_rows.push_back(checked_row(24'hA5A5A5, 16'h8000,
			{24'hA5A5A5, 8'd0, 1'b1, 1'b1, 9'd1, 1'b0}));
		// Level extends over equal greys, then closes on a new grey.
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'd6));
		directed_rows.push_back(write_row(CFG_NUM_LEVELS, 25'd3));
		directed_rows.push_back(pixel_row(24'h000010, 16'd1));
		directed_rows.push_back(pixel_row(24'h000011, 16'd1));
		directed_rows.push_back(pixel_row(24'h000012, 16'd1));
		directed_rows.push_back(pixel_row(24'h000013, 16'd2));
		directed_rows.push_back(pixel_row(24'h000014, 16'd3));
		directed_rows.push_back(pixel_row(24'h000015, 16'd3));
		// Zero quota: grey zero stays on level 0, a new grey jumps several levels.
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'd3));
		directed_rows.push_back(write_row(CFG_NUM_LEVELS, 25'd8));
		directed_rows.push_back(pixel_row(24'h000020, 16'd0));
		directed_rows.push_back(pixel_row(24'h000021, 16'd0));
		directed_rows.push_back(pixel_row(24'h000022, 16'd7));
		// Level count above the maximum is clipped; almost every level is skipped.
		directed_rows.push_back(write_row(CFG_NUM_LEVELS, 25'd511));
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'd2));
		directed_rows.push_back(pixel_row(24'h000030, 16'd5));
		directed_rows.push_back(pixel_row(24'h000031, 16'd5));
		// Lowering the total mid-pass makes pixels overrun until it is raised again.
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'd5));
		directed_rows.push_back(write_row(CFG_NUM_LEVELS, 25'd2));
		directed_rows.push_back(pixel_row(24'h000040, 16'd10));
		directed_rows.push_back(pixel_row(24'h000041, 16'd20));
		directed_rows.push_back(pixel_row(24'h000042, 16'd30));
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'd2));
		directed_rows.push_back(checked_row(24'hC0FFEE, 16'd40,
			{24'hC0FFEE, 8'd0, 1'b0, 1'b0, 9'd0, 1'b1}));
		directed_rows.push_back(checked_row(24'h800001, 16'hFFFF,
			{24'h800001, 8'd0, 1'b0, 1'b0, 9'd0, 1'b1}));
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'd4));
		directed_rows.push_back(pixel_row(24'h000043, 16'd40));
		// Upper data bits of the level count are dropped; the unmapped index is ignored.
		directed_rows.push_back(write_row(CFG_NUM_LEVELS, 25'h1FFFE04));
		directed_rows.push_back(write_row(CFG_UNMAPPED, 25'h1FFFFFF));
		directed_rows.push_back(write_row(CFG_TOTAL_PIXELS, 25'h1FFFFFF));
		directed_rows.push_back(pixel_row(24'h000050, 16'd0));
		directed_rows.push_back(pixel_row(24'h000051, 16'd0));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_block();
				cfg_write(directed_rows[i].reg_index, directed_rows[i].reg_value);
			end else begin
				pause_sender();
				send_pixel(directed_rows[i].pixel_index, directed_rows[i].grey,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random passes: sorted grey runs with repeats, some jumbled, some split by
		// register writes in the middle of a pass.
		random_goal = graded_pixels + RANDOM_PIXELS;
		while (graded_pixels < random_goal) begin
			drain_block();
			tx_pace = pace_e'($urandom_range(2));
			rx_pace = pace_e'($urandom_range(2));
			if (pass_pos == 0) begin
				pick = $urandom_range(9);
				if (pick == 0)
					cfg_write(CFG_TOTAL_PIXELS, $urandom_range(1));
				else if (pick <= 7)
					cfg_write(CFG_TOTAL_PIXELS, $urandom_range(40, 2));
				else
					cfg_write(CFG_TOTAL_PIXELS, $urandom_range(300, 41));
				if ($urandom_range(3) != 0)
					cfg_write(CFG_NUM_LEVELS, draw_level_count());
			end else begin
				pick = $urandom_range(5);
				eff_total = (total_reg == 0) ? 1 : total_reg;
				if (pick == 0)
					cfg_write(CFG_TOTAL_PIXELS, $urandom_range(pass_pos));
				else if (pick <= 3 || eff_total > pass_pos + 400)
					cfg_write(CFG_TOTAL_PIXELS, pass_pos + $urandom_range(40, 1));
				if ($urandom_range(2) == 0)
					cfg_write(CFG_NUM_LEVELS, draw_level_count());
			end

			eff_total = (total_reg == 0) ? 1 : total_reg;
			if (pass_pos >= eff_total)
				burst = $urandom_range(4, 1);
			else if (eff_total - pass_pos <= 60)
				burst = eff_total - pass_pos;
			else
				burst = $urandom_range(60, 20);
			jumble = ($urandom_range(9) == 0);

			repeat (burst) begin
				if (pass_pos == 0) begin
					shade = ($urandom_range(3) == 0) ? '0 : $urandom_range(65535);
					case ($urandom_range(2))
						0: stride = 1;
						1: stride = 64;
						default: stride = 8192;
					endcase
				end else if ($urandom_range(9) >= 4) begin
					step_grey = shade + $urandom_range(stride, 1);
					shade = (step_grey > 65535) ? 16'hFFFF : step_grey;
				end
				g = jumble ? $urandom_range(65535) : shade;
				pause_sender();
				send_pixel($urandom, g, 1'b0, '0);
			end
		end

		drain_block();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ecgq_pkg.sv
hw/rtl/ecgq_div.sv
hw/rtl/equal_count_grey_quantizer_core.sv
hw/rtl/ecgq_checker.sv
test/equal_count_grey_quantizer_core_test.sv
